// ===== rtl/pid2_pkg.sv =====
// Shared types and constants of the two-degree-of-freedom PID unit.
`timescale 1ns / 1ps

package pid2_pkg;

    // Datapath widths
    localparam int GAIN_W  = 32;             // gain and multiplier operand width
    localparam int ACC_W   = 48;             // Q32.16 accumulator width
    localparam int TRK_W   = 40;             // Q24.16 derivative tracking width
    localparam int FRAC_W  = 16;             // fractional bits of all Q.16 values
    localparam int SIG_W   = 16;             // signal width
    localparam int DIG_W   = 4;              // multiplier digit per cycle
    localparam int MUL_STEPS = GAIN_W / DIG_W;
    localparam int CNT_W   = $clog2(MUL_STEPS);

    // Register indexes
    localparam logic [2:0] REG_PROP_GAIN   = 3'd0;
    localparam logic [2:0] REG_PROP_WEIGHT = 3'd1;
    localparam logic [2:0] REG_INTEG_GAIN  = 3'd2;
    localparam logic [2:0] REG_WINDUP_GAIN = 3'd3;
    localparam logic [2:0] REG_DERIV_GAIN  = 3'd4;
    localparam logic [2:0] REG_DERIV_ALPHA = 3'd5;
    localparam logic [2:0] REG_OUT_MIN     = 3'd6;
    localparam logic [2:0] REG_OUT_MAX     = 3'd7;

    // Saturation status codes
    localparam logic [1:0] SAT_NONE = 2'd0;
    localparam logic [1:0] SAT_HIGH = 2'd1;
    localparam logic [1:0] SAT_LOW  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_BR,
        S_P,
        S_D,
        S_SUM,
        S_CLAMP,
        S_W,
        S_I,
        S_X,
        S_ACC,
        S_OUT
    } t_state;

    // Request to the serial multiplier
    typedef struct packed {
        logic              start;
        logic [GAIN_W-1:0] k;      // signed multiplier, consumed a digit per cycle
        logic [ACC_W-1:0]  a;      // signed multiplicand
    } t_mul_req;

    // Response of the serial multiplier
    typedef struct packed {
        logic             busy;
        logic             done;    // one-cycle pulse, prod valid with it
        logic [ACC_W-1:0] prod;    // sat48(floor(k * a / 2^16))
    } t_mul_rsp;

endpackage

// ===== rtl/pid2_serial_mul.sv =====
// Digit-serial multiplier: floor(k * a / 2^16) saturated to 48 bits.
`timescale 1ns / 1ps

module pid2_serial_mul
    import pid2_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    localparam int ACCX_W = ACC_W + 6;
    localparam int PP_W   = ACC_W + DIG_W + 1;
    localparam int FULL_W = ACCX_W + GAIN_W - FRAC_W;

    logic                     r_busy;
    logic                     r_fin;
    logic [CNT_W-1:0]         r_cnt;
    logic [GAIN_W-1:0]        r_k;
    logic signed [ACC_W-1:0]  r_a;
    logic signed [ACCX_W-1:0] r_acc;
    logic [GAIN_W-1:0]        r_low;

    logic                     w_last;
    logic signed [DIG_W:0]    w_dig;
    logic signed [PP_W-1:0]   w_pp;
    logic signed [ACCX_W-1:0] w_sum;
    logic [FULL_W-1:0]        w_full;
    logic                     w_fits;

    // top digit of k carries the sign
    assign w_last = (r_cnt == CNT_W'(MUL_STEPS - 1));
    assign w_dig  = w_last ? $signed({r_k[DIG_W-1], r_k[DIG_W-1:0]})
                           : $signed({1'b0, r_k[DIG_W-1:0]});
    assign w_pp   = w_dig * r_a;
    assign w_sum  = r_acc + $signed({w_pp[PP_W-1], w_pp});

    // product = acc * 2^32 + low; drop 16 fraction bits
    assign w_full = {r_acc, r_low[GAIN_W-1:FRAC_W]};
    assign w_fits = (&w_full[FULL_W-1:ACC_W-1]) | ~(|w_full[FULL_W-1:ACC_W-1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_fin <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_k   <= i_req.k;
            r_a   <= $signed(i_req.a);
            r_acc <= '0;
            r_low <= '0;
        end else if (r_busy) begin
            r_k   <= {{DIG_W{1'b0}}, r_k[GAIN_W-1:DIG_W]};
            r_acc <= w_sum >>> DIG_W;
            r_low <= {w_sum[DIG_W-1:0], r_low[GAIN_W-1:DIG_W]};
        end
    end

    always_comb begin
        o_rsp.busy = r_busy;
        o_rsp.done = r_fin;
        if (w_fits) begin
            o_rsp.prod = w_full[ACC_W-1:0];
        end else if (w_full[FULL_W-1]) begin
            o_rsp.prod = {1'b1, {(ACC_W-1){1'b0}}};
        end else begin
            o_rsp.prod = {1'b0, {(ACC_W-1){1'b1}}};
        end
    end

endmodule

// ===== rtl/pid_2dof_filtered_antiwindup_unit.sv =====
// Top level of the two-degree-of-freedom PID unit with back-calculation anti-windup.
`timescale 1ns / 1ps

// Channel   Dir  Handshake                  Payload (lowest bit up)
// s_axis    in   tvalid/tready              tdata: setpoint[15:0], measured[31:16];
//                                           tuser: clear_state
// m_axis    out  tvalid/tready              tdata: drive[15:0], sat_status[17:16], 0 pad
// cfg       in   we (no wait)               addr[2:0] register index, wdata[31:0]
//
// One item at a time. A normal item runs six products one after another through the shared
// digit-serial multiplier, 4 bits of the gain per cycle (8 steps plus start and capture each):
// load first, sum and clamp after the third product, state update and output after the
// sixth. A clear item goes from load straight to output.
// Reset loads the register defaults and zeroes both controller states.
// The result sits in an output register; a stalled output holds only the final
// hand-over, and the next item can be accepted while the result waits.

module pid_2dof_filtered_antiwindup_unit
    import pid2_pkg::*;
#(
    parameter int DERIV_SETPOINT_WEIGHT = 65536    // c in Q1.16, 0 .. 131072
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,    // setpoint[15:0], measured[31:16]
    input  logic        i_s_axis_tuser,    // clear_state
    // result items
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,    // drive[15:0], sat_status[17:16], zero pad
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_wdata
);

    localparam logic signed [18:0] DSW = 19'(DERIV_SETPOINT_WEIGHT);
    localparam int V_W = 35;                 // c*r - y, Q.16
    localparam int D_W = TRK_W + 1;          // v - w
    localparam int U_W = ACC_W + 2;          // p + i + d

    // configuration
    logic [GAIN_W-1:0]   r_kp;
    logic [GAIN_W-2:0]   r_b;
    logic [GAIN_W-1:0]   r_ki;
    logic [GAIN_W-2:0]   r_ts;
    logic [GAIN_W-1:0]   r_kd;
    logic [16:0]         r_alpha;
    logic [SIG_W-1:0]    r_omin;
    logic [SIG_W-1:0]    r_omax;

    // controller state
    logic [ACC_W-1:0]    r_integ;
    logic [TRK_W-1:0]    r_track;

    // control
    t_state              r_state;
    t_state              n_state;
    logic                r_go;
    logic                n_go;
    logic                r_out_valid;

    // item working registers
    logic [SIG_W-1:0]    r_r;
    logic [SIG_W-1:0]    r_y;
    logic                r_clr;
    logic [V_W-1:0]      r_v;
    logic [D_W-1:0]      r_diff;
    logic [ACC_W-1:0]    r_t;
    logic [ACC_W-1:0]    r_p;
    logic [ACC_W-1:0]    r_d;
    logic [U_W-1:0]      r_u;
    logic [ACC_W-1:0]    r_exc;
    logic [ACC_W-1:0]    r_inc1;
    logic [ACC_W:0]      r_inc2;
    logic [1:0]          r_stat;

    // output register
    logic [SIG_W-1:0]    r_out_drive;
    logic [1:0]          r_out_stat;

    t_mul_req            w_mul_req;
    t_mul_rsp            w_mul_rsp;

    logic signed [V_W-1:0] w_cr;
    logic [V_W-1:0]      w_v;
    logic [SIG_W:0]      w_rmy;
    logic [U_W-1:0]      w_hi;
    logic [U_W-1:0]      w_lo;
    logic [U_W:0]        w_dh;
    logic [U_W:0]        w_dl;
    logic [TRK_W+8:0]    w_trk_sum;
    logic [U_W-1:0]      w_int_sum;
    logic                w_out_load;

    function automatic logic [ACC_W-1:0] sat48_51(input logic [U_W:0] x);
        if ((&x[U_W:ACC_W-1]) | ~(|x[U_W:ACC_W-1])) begin
            return x[ACC_W-1:0];
        end else if (x[U_W]) begin
            return {1'b1, {(ACC_W-1){1'b0}}};
        end else begin
            return {1'b0, {(ACC_W-1){1'b1}}};
        end
    endfunction

    function automatic logic [ACC_W-1:0] sat48_50(input logic [U_W-1:0] x);
        if ((&x[U_W-1:ACC_W-1]) | ~(|x[U_W-1:ACC_W-1])) begin
            return x[ACC_W-1:0];
        end else if (x[U_W-1]) begin
            return {1'b1, {(ACC_W-1){1'b0}}};
        end else begin
            return {1'b0, {(ACC_W-1){1'b1}}};
        end
    endfunction

    function automatic logic [TRK_W-1:0] sat40_49(input logic [TRK_W+8:0] x);
        if ((&x[TRK_W+8:TRK_W-1]) | ~(|x[TRK_W+8:TRK_W-1])) begin
            return x[TRK_W-1:0];
        end else if (x[TRK_W+8]) begin
            return {1'b1, {(TRK_W-1){1'b0}}};
        end else begin
            return {1'b0, {(TRK_W-1){1'b1}}};
        end
    endfunction

    pid2_serial_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mul_req),
        .o_rsp   (w_mul_rsp)
    );

    // v = c*r - y, one constant product
    assign w_cr  = DSW * $signed(r_r);
    assign w_v   = w_cr - {{(V_W-SIG_W-FRAC_W){r_y[SIG_W-1]}}, r_y, {FRAC_W{1'b0}}};
    assign w_rmy = {r_r[SIG_W-1], r_r} - {r_y[SIG_W-1], r_y};

    // limits and clamp distances; u > hi when hi - u < 0, u < lo when lo - u > 0
    assign w_hi  = {{(U_W-SIG_W-FRAC_W){r_omax[SIG_W-1]}}, r_omax, {FRAC_W{1'b0}}};
    assign w_lo  = {{(U_W-SIG_W-FRAC_W){r_omin[SIG_W-1]}}, r_omin, {FRAC_W{1'b0}}};
    assign w_dh  = {w_hi[U_W-1], w_hi} - {r_u[U_W-1], r_u};
    assign w_dl  = {w_lo[U_W-1], w_lo} - {r_u[U_W-1], r_u};

    assign w_trk_sum = {{9{r_track[TRK_W-1]}}, r_track}
                     + {w_mul_rsp.prod[ACC_W-1], w_mul_rsp.prod};
    assign w_int_sum = {{2{r_integ[ACC_W-1]}}, r_integ} + {r_inc2[ACC_W], r_inc2};

    assign w_out_load = (r_state == S_OUT) && (!r_out_valid || i_m_axis_tready);

    // next state, multiplier requests and operand selection
    always_comb begin
        n_state         = r_state;
        n_go            = r_go;
        w_mul_req.start = 1'b0;
        w_mul_req.k     = r_kp;
        w_mul_req.a     = {{(ACC_W-D_W){r_diff[D_W-1]}}, r_diff};
        o_s_axis_tready = (r_state == S_IDLE) && i_rst_n;

        case (r_state)
            S_BR: begin
                w_mul_req.k = {1'b0, r_b};
                w_mul_req.a = {{(ACC_W-SIG_W-FRAC_W){r_r[SIG_W-1]}}, r_r, {FRAC_W{1'b0}}};
            end
            S_P: begin
                w_mul_req.k = r_kp;
                w_mul_req.a = r_t - {{(ACC_W-SIG_W-FRAC_W){r_y[SIG_W-1]}}, r_y,
                                     {FRAC_W{1'b0}}};
            end
            S_D: begin
                w_mul_req.k = r_kd;
            end
            S_W: begin
                w_mul_req.k = {{(GAIN_W-17){1'b0}}, r_alpha};
            end
            S_I: begin
                w_mul_req.k = r_ki;
                w_mul_req.a = {{(ACC_W-SIG_W-1-FRAC_W){w_rmy[SIG_W]}}, w_rmy,
                               {FRAC_W{1'b0}}};
            end
            S_X: begin
                w_mul_req.k = {1'b0, r_ts};
                w_mul_req.a = r_exc;
            end
            default: begin
            end
        endcase

        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_state = r_clr ? S_OUT : S_BR;
            end
            S_BR, S_P, S_D, S_W, S_I, S_X: begin
                if (!r_go) begin
                    w_mul_req.start = 1'b1;
                    n_go            = 1'b1;
                end else if (w_mul_rsp.done) begin
                    n_go = 1'b0;
                    case (r_state)
                        S_BR:    n_state = S_P;
                        S_P:     n_state = S_D;
                        S_D:     n_state = S_SUM;
                        S_W:     n_state = S_I;
                        S_I:     n_state = S_X;
                        default: n_state = S_ACC;
                    endcase
                end
            end
            S_SUM: begin
                n_state = S_CLAMP;
            end
            S_CLAMP: begin
                n_state = S_W;
            end
            S_ACC: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_go    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_go    <= n_go;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp    <= 32'd65536;
            r_b     <= 31'd65536;
            r_ki    <= '0;
            r_ts    <= '0;
            r_kd    <= '0;
            r_alpha <= 17'd65536;
            r_omin  <= 16'h8000;
            r_omax  <= 16'h7FFF;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_PROP_GAIN:   r_kp    <= i_cfg_wdata;
                REG_PROP_WEIGHT: r_b     <= i_cfg_wdata[GAIN_W-2:0];
                REG_INTEG_GAIN:  r_ki    <= i_cfg_wdata;
                REG_WINDUP_GAIN: r_ts    <= i_cfg_wdata[GAIN_W-2:0];
                REG_DERIV_GAIN:  r_kd    <= i_cfg_wdata;
                REG_DERIV_ALPHA: r_alpha <= i_cfg_wdata[16:0];
                REG_OUT_MIN:     r_omin  <= i_cfg_wdata[SIG_W-1:0];
                REG_OUT_MAX:     r_omax  <= i_cfg_wdata[SIG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // controller state: integrator and derivative tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
            r_track <= '0;
        end else begin
            if (r_state == S_LOAD && r_clr) begin
                r_integ <= '0;
                r_track <= '0;
            end
            // derivative track moves only with a nonzero derivative gain
            if (r_state == S_W && r_go && w_mul_rsp.done && (r_kd != '0)) begin
                r_track <= sat40_49(w_trk_sum);
            end
            // integrator and back-calculation both held when Ki is zero
            if (r_state == S_ACC && (r_ki != '0)) begin
                r_integ <= sat48_50(w_int_sum);
            end
        end
    end

    // item datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    r_r   <= i_s_axis_tdata[SIG_W-1:0];
                    r_y   <= i_s_axis_tdata[2*SIG_W-1:SIG_W];
                    r_clr <= i_s_axis_tuser;
                end
            end
            S_LOAD: begin
                r_v <= w_v;
                if (r_clr) begin
                    r_u    <= '0;
                    r_stat <= SAT_NONE;
                end
            end
            S_BR: begin
                r_diff <= {{(D_W-V_W){r_v[V_W-1]}}, r_v} - {r_track[TRK_W-1], r_track};
                if (r_go && w_mul_rsp.done) begin
                    r_t <= w_mul_rsp.prod;
                end
            end
            S_P: begin
                if (r_go && w_mul_rsp.done) begin
                    r_p <= w_mul_rsp.prod;
                end
            end
            S_D: begin
                if (r_go && w_mul_rsp.done) begin
                    r_d <= (r_kd == '0) ? '0 : w_mul_rsp.prod;
                end
            end
            S_SUM: begin
                r_u <= {{2{r_p[ACC_W-1]}}, r_p} + {{2{r_integ[ACC_W-1]}}, r_integ}
                     + {{2{r_d[ACC_W-1]}}, r_d};
            end
            S_CLAMP: begin
                // high test first, so with inverted limits a result above out_max clamps high
                if (w_dh[U_W]) begin
                    r_exc  <= sat48_51(w_dh);
                    r_u    <= w_hi;
                    r_stat <= SAT_HIGH;
                end else if (!w_dl[U_W] && (w_dl != '0)) begin
                    r_exc  <= sat48_51(w_dl);
                    r_u    <= w_lo;
                    r_stat <= SAT_LOW;
                end else begin
                    r_exc  <= '0;
                    r_stat <= SAT_NONE;
                end
            end
            S_I: begin
                if (r_go && w_mul_rsp.done) begin
                    r_inc1 <= w_mul_rsp.prod;
                end
            end
            S_X: begin
                if (r_go && w_mul_rsp.done) begin
                    r_inc2 <= {r_inc1[ACC_W-1], r_inc1}
                            + {w_mul_rsp.prod[ACC_W-1], w_mul_rsp.prod};
                end
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_drive <= r_u[FRAC_W+SIG_W-1:FRAC_W];
            r_out_stat  <= r_stat;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'b0, r_out_stat, r_out_drive};

    // multiplier is never restarted mid-product
    a_mul_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_req.start |-> !w_mul_rsp.busy)
        else $error("multiplier started while busy");

    // a new item never arrives while a product is in flight
    a_accept_mul_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |-> !w_mul_rsp.busy)
        else $error("item accepted while multiplier busy");

    // a clamped result sits exactly on its limit
    a_clamp_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_stat == SAT_HIGH) |-> (r_out_drive == r_omax))
        else $error("high clamp does not match out_max");

    a_clamp_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_stat == SAT_LOW) |-> (r_out_drive == r_omin))
        else $error("low clamp does not match out_min");

endmodule
